@@ hw/rtl/deq_pkg.sv @@
// deq_pkg: shared types, constants and ring helpers for the deque with search
// used by deq_ctrl and double_ended_queue_with_search; depends on nothing
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = PTR_W + 1;

  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_BACK   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_QUERY      = 3'd4;
  localparam logic [2:0] CMD_SEARCH     = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_MISS  = 2'd3;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic [1:0]         status;
    logic [4:0]         found_pos;
    logic               no_entries;
    logic [4:0]         entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POPRD,
    S_SCAN,
    S_DONE
  } state_t;

  // (head + off) mod DEPTH, with off no larger than DEPTH
  function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(head) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

@@ hw/rtl/deq_ram.sv @@
// deq_ram: generic single-write, single-read synchronous ram, registered read
// no package dependency
module deq_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 4,
  parameter int WORDS  = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// deq_ctrl: command sequencer, head/count pointers and search walk over the ring ram
// depends on deq_pkg and deq_ram
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res_data
);

  state_t                 state, state_next;
  logic [2:0]             cmd;
  logic [DATA_WIDTH-1:0]  val;
  logic [PTR_W-1:0]       head;
  logic [CNT_W-1:0]       count;
  logic [PTR_W-1:0]       idx;
  logic signed [31:0]     res_dout;
  logic [1:0]             res_status;
  logic [4:0]             res_pos;

  logic                   ram_we;
  logic [PTR_W-1:0]       ram_waddr;
  logic [PTR_W-1:0]       ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  logic full, empty, match, last;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign match = (ram_rdata == val);
  assign last  = ((CNT_W'(idx) + CNT_W'(1)) == count);

  deq_ram #(
    .DATA_W (DATA_WIDTH),
    .ADDR_W (PTR_W),
    .WORDS  (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if ((cmd == CMD_POP_BACK || cmd == CMD_POP_FRONT) && !empty) begin
          state_next = S_POPRD;
        end else if (cmd == CMD_SEARCH && !empty) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_DONE;
        end
      end
      S_POPRD: state_next = S_DONE;
      S_SCAN: begin
        if (match || last) state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and ram access
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ring_slot(head, count);
    ram_raddr = head;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        unique case (cmd)
          CMD_PUSH_BACK: begin
            ram_we    = !full;
            ram_waddr = ring_slot(head, count);
          end
          CMD_PUSH_FRONT: begin
            ram_we    = !full;
            ram_waddr = ring_slot(head, CNT_W'(DEPTH - 1));
          end
          CMD_POP_BACK: ram_raddr = ring_slot(head, count - CNT_W'(1));
          default: ram_raddr = head;
        endcase
      end
      S_SCAN: ram_raddr = ring_slot(head, CNT_W'(idx) + CNT_W'(1));
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd <= in_data.command;
            val <= DATA_WIDTH'(in_data.data_in);
          end
        end
        S_EXEC: begin
          res_dout <= '0;
          res_pos  <= '0;
          idx      <= '0;
          unique case (cmd)
            CMD_PUSH_BACK: begin
              res_status <= full ? STAT_FULL : STAT_OK;
              if (!full) count <= count + CNT_W'(1);
            end
            CMD_PUSH_FRONT: begin
              res_status <= full ? STAT_FULL : STAT_OK;
              if (!full) begin
                head  <= ring_slot(head, CNT_W'(DEPTH - 1));
                count <= count + CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              res_status <= empty ? STAT_EMPTY : STAT_OK;
              if (!empty) count <= count - CNT_W'(1);
            end
            CMD_POP_FRONT: begin
              res_status <= empty ? STAT_EMPTY : STAT_OK;
              if (!empty) begin
                head  <= ring_slot(head, CNT_W'(1));
                count <= count - CNT_W'(1);
              end
            end
            CMD_SEARCH: res_status <= empty ? STAT_MISS : STAT_OK;
            default: res_status <= STAT_OK;
          endcase
        end
        S_POPRD: res_dout <= 32'(signed'(ram_rdata));
        S_SCAN: begin
          // read of the next entry is already issued while this one compares
          if (match) begin
            res_pos <= 5'(CNT_W'(idx) + CNT_W'(1));
          end else if (last) begin
            res_status <= STAT_MISS;
          end else begin
            idx <= idx + PTR_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_data.data_out    = res_dout;
    res_data.status      = res_status;
    res_data.found_pos   = res_pos;
    res_data.no_entries  = empty;
    res_data.entry_count = 5'(count);
  end

endmodule

@@ hw/rtl/double_ended_queue_with_search.sv @@
// double_ended_queue_with_search: top level, command sequencer plus output register
// depends on deq_pkg and deq_ctrl
//
// Bounded deque of DEPTH signed words held in a ring ram, with head and count.
// Input channel (in_valid/in_ready/in_data) takes one command beat: push back,
// push front, pop back, pop front, query empty or search. Every command gives
// exactly one result beat on the output channel (out_valid/out_ready/out_data)
// with popped data, status, found position, and the fill after the command.
// Commands are handled one at a time. From accept the sequencer steps:
//   push, query, refused commands: EXEC, then DONE with the result valid
//   pop of a held entry: EXEC, POPRD for the ram read, then DONE
//   search: EXEC, then SCAN walks one ring entry per cycle through the single
//   read port up to the first match, or the whole fill on a miss, then DONE
// A new command can be taken in the cycle after the previous result enters the
// output register, even while that result still waits. If the receiver stalls
// with a result held, the next command runs and then waits until the register
// frees.
// Reset empties the deque (head and count to zero); ram contents are not cleared.
module double_ended_queue_with_search
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted while another is in flight");

  a_result_loads: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> out_valid && !res_valid)
    else $error("result beat not moved into output register");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == STAT_EMPTY |->
      out_data.no_entries && out_data.data_out == 0)
    else $error("pop on empty reported with data or nonempty fill");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found_pos != 0 |->
      out_data.status == STAT_OK && !out_data.no_entries)
    else $error("found position without ok status");
`endif

endmodule

@@ dv/double_ended_queue_with_search_tb.sv @@
// double_ended_queue_with_search_tb: self-checking bench for the deque with search,
// a shadow deque predicts every reply and random valid/ready traffic drives the block
// depends on deq_pkg and double_ended_queue_with_search
`timescale 1ns / 1ps

module double_ended_queue_with_search_tb;
  import deq_pkg::*;

  localparam logic [2:0] CMD_UNDEF_6 = 3'd6;
  localparam logic [2:0] CMD_UNDEF_7 = 3'd7;
  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_CYCLES  = 300;
  // the slowest legal run stays well under this (search walks, idle gaps, one long hold)
  localparam int CYCLE_LIMIT  = 1000000;

  // shadow copy of the ring, head and fill; owes one reply per accepted command
  class deque_shadow;
    logic [DATA_WIDTH-1:0] ring[DEPTH];
    int head;
    int fill;
    out_item_t replies_due[$];
    int errors;

    function new();
      head = 0;
      fill = 0;
      errors = 0;
    endfunction

    function logic signed [31:0] held_word(int offset);
      return $signed(ring[(head + offset) % DEPTH]);
    endfunction

    function void apply_command(in_item_t c);
      out_item_t r;
      logic [DATA_WIDTH-1:0] v;
      int slot;
      r = '0;
      v = DATA_WIDTH'(c.data_in);
      case (c.command)
        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
          if (fill == DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            if (c.command == CMD_PUSH_FRONT) begin
              head = (head + DEPTH - 1) % DEPTH;
              ring[head] = v;
            end else begin
              ring[(head + fill) % DEPTH] = v;
            end
            fill++;
          end
        end
        CMD_POP_BACK, CMD_POP_FRONT: begin
          if (fill == 0) begin
            r.status = STAT_EMPTY;
          end else begin
            if (c.command == CMD_POP_BACK) begin
              slot = (head + fill - 1) % DEPTH;
            end else begin
              slot = head;
              head = (head + 1) % DEPTH;
            end
            r.data_out = $signed(ring[slot]);
            fill--;
          end
        end
        CMD_SEARCH: begin
          r.status = STAT_MISS;
          for (int i = 0; i < fill; i++) begin
            if (ring[(head + i) % DEPTH] == v) begin
              r.found_pos = 5'(i + 1);
              r.status = STAT_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      r.no_entries = (fill == 0);
      r.entry_count = 5'(fill);
      replies_due.push_back(r);
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: reply beat with nothing outstanding: data=%0d st=%0d pos=%0d",
                   $realtime, got.data_out, got.status, got.found_pos);
        end
        return;
      end
      want = replies_due[0];
      replies_due.delete(0);
      if (got.data_out !== want.data_out || got.status !== want.status ||
          got.found_pos !== want.found_pos || got.no_entries !== want.no_entries ||
          got.entry_count !== want.entry_count) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: bad reply exp data=%0d st=%0d pos=%0d empty=%0b cnt=%0d",
                   $realtime, want.data_out, want.status, want.found_pos,
                   want.no_entries, want.entry_count);
          $display("%0t:           got data=%0d st=%0d pos=%0d empty=%0b cnt=%0d",
                   $realtime, got.data_out, got.status, got.found_pos,
                   got.no_entries, got.entry_count);
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  deque_shadow shadow = new();
  int tx_idle_pct = 33;
  int rx_idle_pct = 66;
  bit stall_req = 1'b0;
  int cycles = 0;

  double_ended_queue_with_search u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_ended_queue_with_search: mismatch");
      $finish;
    end
  end

  // offer one command beat and hold it until accepted; note it at the accepting edge
  task automatic send_command(logic [2:0] cmd, logic signed [31:0] value);
    in_item_t c;
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    c.command = cmd;
    c.data_in = value;
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.apply_command(c);
  endtask

  function automatic logic signed [31:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      return $urandom_range(4) - 2;
    end else if (r < 30) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  // receiver: random backpressure, plus one long hold-off on request
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
      if (out_valid && out_ready) shadow.check_reply(out_data);
    end
  end

  initial begin
    bit grow;
    int trend_left;
    int r;
    logic [2:0] cmd;
    logic signed [31:0] value;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty deque corner cases and undefined commands
    send_command(CMD_POP_BACK, 32'sd5);
    send_command(CMD_POP_FRONT, -32'sd5);
    send_command(CMD_QUERY, 32'sd0);
    send_command(CMD_SEARCH, 32'sd0);
    send_command(CMD_UNDEF_6, 32'h7fff_ffff);
    send_command(CMD_UNDEF_7, 32'h8000_0000);
    // fill to the top from both ends, starting with extreme words
    for (int k = 0; k < DEPTH; k++) begin
      case (k)
        0: value = 32'h7fff_ffff;
        1: value = 32'h8000_0000;
        2: value = 32'h0;
        3: value = 32'hffff_ffff;
        default: value = $urandom;
      endcase
      send_command(k[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, value);
    end
    send_command(CMD_PUSH_BACK, 32'sd1);
    send_command(CMD_PUSH_FRONT, -32'sd1);
    send_command(CMD_SEARCH, shadow.held_word(DEPTH - 1));
    send_command(CMD_SEARCH, shadow.held_word(7));
    send_command(CMD_SEARCH, 32'h1234_5678);
    send_command(CMD_POP_FRONT, 32'sd0);
    send_command(CMD_POP_BACK, 32'sd0);
    send_command(CMD_QUERY, 32'sd0);

    grow = 1'b0;
    trend_left = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 33; rx_idle_pct = 66; end
        1: begin tx_idle_pct = 66; rx_idle_pct = 33; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          stall_req = 1'b1;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
        // alternate filling and draining runs so full and empty both get reached
        if (trend_left == 0) begin
          grow = !grow;
          trend_left = $urandom_range(8, 40);
        end
        trend_left--;
        r = $urandom_range(99);
        value = pick_word();
        if (r < 2) begin
          cmd = $urandom_range(1) ? CMD_UNDEF_7 : CMD_UNDEF_6;
        end else if (r < 6) begin
          cmd = CMD_QUERY;
        end else if (r < 24) begin
          cmd = CMD_SEARCH;
          if (shadow.fill > 0 && $urandom_range(99) < 65) begin
            value = shadow.held_word($urandom_range(shadow.fill - 1));
          end
        end else if (r < (grow ? 74 : 50)) begin
          cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        end else begin
          cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
        end
        send_command(cmd, value);
      end
    end
    in_valid <= 1'b0;

    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (shadow.errors == 0 && shadow.replies_due.size() == 0) begin
      $display("double_ended_queue_with_search: match");
    end else begin
      $display("double_ended_queue_with_search: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_ctrl.sv
hw/rtl/double_ended_queue_with_search.sv
dv/double_ended_queue_with_search_tb.sv
